// ===== src/bdmc_pkg.sv =====
package bdmc_pkg;

    localparam int NUM_BTN = 5;

    // button positions in the level vectors
    localparam int POS_RIGHT = 0;
    localparam int POS_LEFT  = 1;
    localparam int POS_UP    = 2;
    localparam int POS_DOWN  = 3;
    localparam int POS_OK    = 4;

    localparam logic [2:0] OPM_OFF      = 3'd0;
    localparam logic [2:0] OPM_TRACKING = 3'd1;
    localparam logic [2:0] OPM_PAUSE    = 3'd2;
    localparam logic [2:0] OPM_MANUAL   = 3'd3;
    localparam logic [2:0] OPM_TILT     = 3'd4;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_MODE_GUARD = 2'd2;

    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd40;
    localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1500;
    localparam logic [15:0] MODE_GUARD_MS_RST = 16'd300;

    localparam logic [3:0] JOY_NONE       = 4'd0;
    localparam logic [3:0] JOY_FWD        = 4'd1;
    localparam logic [3:0] JOY_FWD_LEFT   = 4'd2;
    localparam logic [3:0] JOY_LEFT       = 4'd3;
    localparam logic [3:0] JOY_BACK_LEFT  = 4'd4;
    localparam logic [3:0] JOY_BACK       = 4'd5;
    localparam logic [3:0] JOY_BACK_RIGHT = 4'd6;
    localparam logic [3:0] JOY_RIGHT      = 4'd7;
    localparam logic [3:0] JOY_FWD_RIGHT  = 4'd8;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        press_right;
        logic        press_left;
        logic        press_up;
        logic        press_down;
        logic        press_ok;
    } sample_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] joystick;
        logic       mode_changed;
        logic [4:0] stable_levels;
        logic [4:0] rising_edges;
    } result_t;

    // per-button status handed to the mode logic
    typedef struct packed {
        logic stable;
        logic rise;
        logic long_fired;
    } btn_stat_t;

    // mode logic outcome for one sample
    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] joystick;
        logic       changed;
    } mode_res_t;

    // levels: bit0 right, bit1 left, bit2 up, bit3 down
    function automatic logic [3:0] joy_code(input logic [3:0] lv);
        logic r;
        logic l;
        logic u;
        logic d;
        logic [3:0] code;
        r = lv[POS_RIGHT];
        l = lv[POS_LEFT];
        u = lv[POS_UP];
        d = lv[POS_DOWN];
        if ((u && d) || (l && r))
            code = JOY_NONE;
        else if (u && !l && !r)
            code = JOY_FWD;
        else if (u && l)
            code = JOY_FWD_LEFT;
        else if (!u && !d && l)
            code = JOY_LEFT;
        else if (d && l)
            code = JOY_BACK_LEFT;
        else if (d && !l && !r)
            code = JOY_BACK;
        else if (d && r)
            code = JOY_BACK_RIGHT;
        else if (!u && !d && r)
            code = JOY_RIGHT;
        else if (u && r)
            code = JOY_FWD_RIGHT;
        else
            code = JOY_NONE;
        return code;
    endfunction

endpackage

// ===== src/bdmc_button.sv =====
module bdmc_button (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [31:0]         now_ms,
    input  logic                raw_in,
    input  logic [15:0]         debounce_ms,
    input  logic [15:0]         long_press_ms,
    input  logic                restart,
    output bdmc_pkg::btn_stat_t stat
);
    import bdmc_pkg::*;

    logic        raw_reg;
    logic        stable_reg;
    logic [31:0] change_time_reg;
    logic [31:0] press_time_reg;
    logic        long_fired_reg;

    logic        stable_next;
    logic [31:0] change_time_next;
    logic [31:0] press_time_next;
    logic        long_fired_next;

    logic        settled;
    logic        flip;
    logic        rise;
    logic        held_long;
    logic [31:0] ct_eff;
    logic [31:0] pt_eff;
    logic        lf_eff;

    always_comb
    begin
        ct_eff  = (raw_in != raw_reg) ? now_ms : change_time_reg;
        settled = (now_ms - ct_eff) >= {16'd0, debounce_ms};
        flip    = settled && (stable_reg != raw_in);
        stable_next = flip ? raw_in : stable_reg;
        rise    = flip && raw_in;
        // a new press restarts the long-press timer
        pt_eff  = rise ? now_ms : press_time_reg;
        lf_eff  = rise ? 1'b0 : long_fired_reg;
        held_long = stable_next && ((now_ms - pt_eff) >= {16'd0, long_press_ms});
        long_fired_next = lf_eff || held_long;
        change_time_next = ct_eff;
        press_time_next  = pt_eff;
    end

    assign stat.stable     = stable_next;
    assign stat.rise       = rise;
    assign stat.long_fired = long_fired_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg         <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_fired_reg  <= 1'b0;
        end
        else if (en)
        begin
            raw_reg    <= raw_in;
            stable_reg <= stable_next;
            if (restart)
            begin
                change_time_reg <= now_ms;
                press_time_reg  <= now_ms;
                long_fired_reg  <= 1'b0;
            end
            else
            begin
                change_time_reg <= change_time_next;
                press_time_reg  <= press_time_next;
                long_fired_reg  <= long_fired_next;
            end
        end
    end

endmodule

// ===== src/bdmc_mode.sv =====
module bdmc_mode (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic [31:0]                               now_ms,
    input  logic [15:0]                               mode_guard_ms,
    input  bdmc_pkg::btn_stat_t [bdmc_pkg::NUM_BTN-1:0] stat,
    input  logic [3:0]                                raw_levels,
    output bdmc_pkg::mode_res_t                       res
);
    import bdmc_pkg::*;

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [31:0] guard_start_reg;
    logic        guard_open;
    logic        changed;
    logic        any_rise;

    always_comb
    begin
        any_rise = 1'b0;
        for (int i = 0; i < NUM_BTN; i++)
            any_rise = any_rise | stat[i].rise;
    end

    // first event that fires wins: a change clears every flag behind it
    always_comb
    begin
        guard_open = (now_ms - guard_start_reg) >= {16'd0, mode_guard_ms};
        mode_next  = mode_reg;
        changed    = 1'b0;
        if (guard_open)
        begin
            if (stat[POS_OK].long_fired)
            begin
                mode_next = (mode_reg == OPM_OFF) ? OPM_TRACKING : OPM_OFF;
                changed   = 1'b1;
            end
            else if (stat[POS_UP].long_fired)
            begin
                mode_next = OPM_MANUAL;
                changed   = 1'b1;
            end
            else if (stat[POS_LEFT].long_fired)
            begin
                mode_next = OPM_TILT;
                changed   = 1'b1;
            end
            else if (stat[POS_DOWN].rise && mode_reg == OPM_TRACKING)
            begin
                mode_next = OPM_PAUSE;
                changed   = 1'b1;
            end
            else if (mode_reg == OPM_PAUSE && any_rise)
            begin
                mode_next = OPM_TRACKING;
                changed   = 1'b1;
            end
        end
    end

    assign res.mode     = mode_next;
    assign res.changed  = changed;
    assign res.joystick = (mode_next == OPM_MANUAL) ? joy_code(raw_levels) : JOY_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= OPM_OFF;
            guard_start_reg <= '0;
        end
        else if (en)
        begin
            mode_reg <= mode_next;
            if (changed)
                guard_start_reg <= now_ms;
        end
    end

endmodule

// ===== src/button_debounce_mode_controller_top.sv =====
// Channel   Dir   Handshake                    Payload
// sample    in    sample_valid / sample_stall  sample_t: now_ms, five raw levels
// result    out   result_valid / result_stall  result_t: mode, joystick, flags, levels
// cfg       in    cfg_we                       cfg_index selects register, cfg_data
//
// One sample per cycle unless sample_stall is high.
// The sample register feeds one pass of debounce and mode logic into the result register.
// Reset puts all buttons released, mode off and the registers at their defaults.
// A stalled result holds; the sample register keeps taking a new sample as the result moves.
module button_debounce_mode_controller_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  bdmc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output bdmc_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import bdmc_pkg::*;

    logic [15:0] debounce_ms_reg;
    logic [15:0] long_press_ms_reg;
    logic [15:0] mode_guard_ms_reg;

    logic        in_valid_reg;
    sample_t     in_data_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     out_data_next;

    logic        advance;
    logic [NUM_BTN-1:0] raw_levels;
    btn_stat_t [NUM_BTN-1:0] stat;
    mode_res_t   mres;
    logic [NUM_BTN-1:0] stable_bits;
    logic [NUM_BTN-1:0] rise_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_MS_RST;
            long_press_ms_reg <= LONG_PRESS_MS_RST;
            mode_guard_ms_reg <= MODE_GUARD_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_ms_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_ms_reg <= cfg_data;
                REG_MODE_GUARD: mode_guard_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;

    assign raw_levels = {in_data_reg.press_ok, in_data_reg.press_down, in_data_reg.press_up,
                         in_data_reg.press_left, in_data_reg.press_right};

    for (genvar g = 0; g < NUM_BTN; g++)
    begin : g_btn
        bdmc_button u_button (
            .clk          (clk),
            .rst_n        (rst_n),
            .en           (advance),
            .now_ms       (in_data_reg.now_ms),
            .raw_in       (raw_levels[g]),
            .debounce_ms  (debounce_ms_reg),
            .long_press_ms(long_press_ms_reg),
            .restart      (mres.changed),
            .stat         (stat[g])
        );
        assign stable_bits[g] = stat[g].stable;
        assign rise_bits[g]   = stat[g].rise;
    end

    bdmc_mode u_mode (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .now_ms       (in_data_reg.now_ms),
        .mode_guard_ms(mode_guard_ms_reg),
        .stat         (stat),
        .raw_levels   (raw_levels[3:0]),
        .res          (mres)
    );

    always_comb
    begin
        out_data_next.mode          = mres.mode;
        out_data_next.joystick      = mres.joystick;
        out_data_next.mode_changed  = mres.changed;
        out_data_next.stable_levels = stable_bits;
        out_data_next.rising_edges  = rise_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
                in_valid_reg <= sample_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
            in_data_reg <= sample;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== tb/sv/button_debounce_mode_controller_top_tb.sv =====
`timescale 1ns / 1ps

module button_debounce_mode_controller_top_tb;

    import bdmc_pkg::*;

    localparam logic [4:0] RIGHT_BTN = 5'd1 << POS_RIGHT;
    localparam logic [4:0] LEFT_BTN  = 5'd1 << POS_LEFT;
    localparam logic [4:0] UP_BTN    = 5'd1 << POS_UP;
    localparam logic [4:0] DOWN_BTN  = 5'd1 << POS_DOWN;
    localparam logic [4:0] OK_BTN    = 5'd1 << POS_OK;
    localparam logic [4:0] ALL_BTN   = 5'h1F;

    localparam int LONG_HOLD_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // shadow of the block's registers and per-button state
    logic [15:0] cfg_debounce   = DEBOUNCE_MS_RST;
    logic [15:0] cfg_long_press = LONG_PRESS_MS_RST;
    logic [15:0] cfg_guard      = MODE_GUARD_MS_RST;
    logic [4:0]  btn_raw    = '0;
    logic [4:0]  btn_stable = '0;
    logic [4:0]  btn_prior  = '0;
    logic [4:0]  btn_rise   = '0;
    logic [4:0]  btn_long   = '0;
    logic [31:0] btn_change_ms [NUM_BTN] = '{default: '0};
    logic [31:0] btn_press_ms  [NUM_BTN] = '{default: '0};
    logic [2:0]  cur_mode    = OPM_OFF;
    logic [31:0] guard_start = '0;

    result_t     pending_mode_results [$];
    logic [31:0] clock_ms;
    bit          idle_on;
    bit          long_hold_req;
    int          error_count;
    int          samples_sent;
    int          results_checked;
    int          mode_changes;
    int          settings_applied;

    button_debounce_mode_controller_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void restart_button_timers(input logic [31:0] now);
        guard_start = now;
        btn_prior = btn_stable;
        btn_rise = '0;
        btn_long = '0;
        for (int i = 0; i < NUM_BTN; i++)
        begin
            btn_press_ms[i] = now;
            btn_change_ms[i] = now;
        end
    endfunction

    // debounce, long press, mode switching and joystick for one sample
    function automatic result_t next_mode_result(input sample_t s);
        logic [31:0] now;
        logic [31:0] elapsed;
        logic [4:0]  levels;
        logic        changed;
        logic        done;
        result_t     r;
        now = s.now_ms;
        levels = '0;
        levels[POS_RIGHT] = s.press_right;
        levels[POS_LEFT]  = s.press_left;
        levels[POS_UP]    = s.press_up;
        levels[POS_DOWN]  = s.press_down;
        levels[POS_OK]    = s.press_ok;
        changed = 1'b0;
        done = 1'b0;

        for (int i = 0; i < NUM_BTN; i++)
        begin
            if (levels[i] != btn_raw[i])
            begin
                btn_raw[i] = levels[i];
                btn_change_ms[i] = now;
            end
            elapsed = now - btn_change_ms[i];
            if (elapsed >= {16'd0, cfg_debounce} && btn_stable[i] != btn_raw[i])
            begin
                btn_prior[i] = btn_stable[i];
                btn_stable[i] = btn_raw[i];
                btn_rise[i] = btn_stable[i] & ~btn_prior[i];
                if (btn_rise[i])
                begin
                    btn_press_ms[i] = now;
                    btn_long[i] = 1'b0;
                end
            end
            else
            begin
                btn_rise[i] = 1'b0;
            end
            elapsed = now - btn_press_ms[i];
            if (btn_stable[i] && !btn_long[i] && elapsed >= {16'd0, cfg_long_press})
                btn_long[i] = 1'b1;
        end
        // edges are reported as the debounce stage saw them
        r.stable_levels = btn_stable;
        r.rising_edges = btn_rise;

        elapsed = now - guard_start;
        if (elapsed >= {16'd0, cfg_guard})
        begin
            if (btn_long[POS_OK])
            begin
                cur_mode = (cur_mode == OPM_OFF) ? OPM_TRACKING : OPM_OFF;
                restart_button_timers(now);
                changed = 1'b1;
            end
            if (btn_long[POS_UP])
            begin
                cur_mode = OPM_MANUAL;
                restart_button_timers(now);
                changed = 1'b1;
            end
            if (btn_long[POS_LEFT])
            begin
                cur_mode = OPM_TILT;
                restart_button_timers(now);
                changed = 1'b1;
            end
            if (btn_rise[POS_DOWN] && cur_mode == OPM_TRACKING)
            begin
                cur_mode = OPM_PAUSE;
                restart_button_timers(now);
                changed = 1'b1;
                done = 1'b1;
            end
            if (!done && cur_mode == OPM_PAUSE && btn_rise != '0)
            begin
                cur_mode = OPM_TRACKING;
                restart_button_timers(now);
                changed = 1'b1;
            end
        end

        r.joystick = JOY_NONE;
        if (cur_mode == OPM_MANUAL)
        begin
            case ({btn_raw[POS_UP], btn_raw[POS_DOWN], btn_raw[POS_LEFT], btn_raw[POS_RIGHT]})
                4'b1000: r.joystick = JOY_FWD;
                4'b1010: r.joystick = JOY_FWD_LEFT;
                4'b0010: r.joystick = JOY_LEFT;
                4'b0110: r.joystick = JOY_BACK_LEFT;
                4'b0100: r.joystick = JOY_BACK;
                4'b0101: r.joystick = JOY_BACK_RIGHT;
                4'b0001: r.joystick = JOY_RIGHT;
                4'b1001: r.joystick = JOY_FWD_RIGHT;
                default: r.joystick = JOY_NONE;
            endcase
        end
        r.mode = cur_mode;
        r.mode_changed = changed;
        return r;
    endfunction

    // advance the millisecond clock and offer one sample; returns at acceptance
    task automatic send_sample(input logic [4:0] levels, input int unsigned dt_ms);
        sample_t s;
        result_t want;
        int gap;
        clock_ms = clock_ms + dt_ms;
        s.now_ms = clock_ms;
        s.press_right = levels[POS_RIGHT];
        s.press_left  = levels[POS_LEFT];
        s.press_up    = levels[POS_UP];
        s.press_down  = levels[POS_DOWN];
        s.press_ok    = levels[POS_OK];
        @(negedge clk);
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall !== 1'b0) @(posedge clk);
        want = next_mode_result(s);
        if (want.mode_changed)
            mode_changes++;
        pending_mode_results.push_back(want);
        samples_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_mode_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_config(input logic [15:0] deb, input logic [15:0] lp,
                                input logic [15:0] guard);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= deb;
        @(negedge clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data <= lp;
        @(negedge clk);
        cfg_index <= REG_MODE_GUARD;
        cfg_data <= guard;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_debounce = deb;
        cfg_long_press = lp;
        cfg_guard = guard;
        settings_applied++;
    endtask

    // reset register values: debounce, then long press to tracking
    task automatic test_reset_defaults();
        send_sample(OK_BTN, 0);
        send_sample(OK_BTN, 40);
        send_sample(OK_BTN, 1500);
    endtask

    // walk through the pause, resume, manual, tilt and off transitions and the joystick corner cases
    task automatic test_mode_sequence();
        apply_config(16'd0, 16'd5, 16'd0);
        send_sample('0, 10);
        send_sample(DOWN_BTN, 1);
        send_sample('0, 1);
        send_sample(RIGHT_BTN, 1);
        send_sample(UP_BTN, 1);
        send_sample(UP_BTN, 5);
        // still held: fires again after another long-press time
        send_sample(UP_BTN, 5);
        send_sample(UP_BTN | LEFT_BTN, 1);
        send_sample(UP_BTN | DOWN_BTN, 1);
        send_sample(LEFT_BTN | RIGHT_BTN, 1);
        send_sample(LEFT_BTN, 6);
        send_sample(ALL_BTN, 1);
        send_sample(ALL_BTN, 5);
        send_sample('0, 1);
    endtask

    // long press held back by the guard window, across the 32-bit wrap
    task automatic test_guard_and_wrap();
        apply_config(16'd2, 16'd4, 16'd20);
        clock_ms = 32'hFFFF_FFF0;
        send_sample(OK_BTN, 0);
        send_sample(OK_BTN, 3);
        send_sample(OK_BTN, 5);
        send_sample(OK_BTN, 5);
        send_sample(OK_BTN, 2);
        send_sample(OK_BTN, 20);
        send_sample('0, 1);
    endtask

    // button episodes with random content, plus bounces and time jumps
    task automatic test_random_traffic(input logic [15:0] deb, input logic [15:0] lp,
                                       input logic [15:0] guard, input int count,
                                       input int unsigned max_step, input bit with_idle);
        int sent;
        int pick;
        int run;
        logic [4:0] levels;
        apply_config(deb, lp, guard);
        idle_on = with_idle;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                levels = 5'd1 << $urandom_range(0, NUM_BTN - 1);
            else if (pick < 75)
                levels = 5'($urandom_range(0, 31));
            else if (pick < 88)
                levels = '0;
            else if (pick < 94)
            begin
                // single bounce shorter than the debounce time, usually
                send_sample(5'($urandom_range(0, 31)), $urandom_range(0, max_step / 4));
                sent++;
                continue;
            end
            else
            begin
                clock_ms = $urandom;
                send_sample(5'($urandom_range(0, 31)), 0);
                sent++;
                continue;
            end
            run = $urandom_range(1, 20);
            repeat (run)
            begin
                send_sample(levels, $urandom_range(1, max_step));
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while samples keep coming, so the input must stall
    task automatic test_backpressure();
        drain_results();
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_sample(5'($urandom_range(0, 31)), $urandom_range(1, 5));
        idle_on = 1'b1;
    endtask

    initial
    begin : result_monitor
        int stall_cycles;
        result_t want;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            stall_cycles = idle_on ? $urandom_range(0, 4) : 0;
            if (stall_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (result_valid !== 1'b1) @(posedge clk);
            if (pending_mode_results.size() == 0)
            begin
                $error("unexpected result transaction: mode %0d", result.mode);
                error_count++;
            end
            else
            begin
                want = pending_mode_results.pop_front();
                results_checked++;
                if (result.mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, result.mode);
                    error_count++;
                end
                if (result.joystick !== want.joystick)
                begin
                    $error("joystick: expected %0d, got %0d", want.joystick, result.joystick);
                    error_count++;
                end
                if (result.mode_changed !== want.mode_changed)
                begin
                    $error("mode_changed: expected %0d, got %0d",
                           want.mode_changed, result.mode_changed);
                    error_count++;
                end
                if (result.stable_levels !== want.stable_levels)
                begin
                    $error("stable_levels: expected %05b, got %05b",
                           want.stable_levels, result.stable_levels);
                    error_count++;
                end
                if (result.rising_edges !== want.rising_edges)
                begin
                    $error("rising_edges: expected %05b, got %05b",
                           want.rising_edges, result.rising_edges);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #400000;
        $display("[button_debounce_mode_controller_top] ERROR");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_data = '0;
        clock_ms = '0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_mode_sequence();
        test_guard_and_wrap();
        test_random_traffic(16'd3, 16'd20, 16'd10, 110, 6, 1'b1);
        test_random_traffic(16'd0, 16'd0, 16'd0, 60, 3, 1'b1);
        test_random_traffic(DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, MODE_GUARD_MS_RST,
                            100, 200, 1'b0);
        test_random_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 30000, 1'b1);
        test_random_traffic(16'd1, 16'd8, 16'd3, 80, 4, 1'b1);
        test_backpressure();

        drain_results();
        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d samples over %0d register settings;",
                 results_checked, samples_sent, settings_applied);
        $display("%0d of them changed the mode, %0d mismatches.", mode_changes, error_count);
        if (error_count == 0)
            $display("[button_debounce_mode_controller_top] OK");
        else
            $display("[button_debounce_mode_controller_top] ERROR");
        $finish;
    end

endmodule
